FILE: rtl/rtvs_pkg.sv
`timescale 1ns / 1ps
package rtvs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_SAMPLES = 65536;
  localparam int CNT_W       = 17;
  localparam int SUM_W       = 33;
  localparam int SQ_W        = 47;
  localparam int XY_W        = 48;
  localparam int DW          = 128;
  localparam int LEN_W       = 7;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic             start;
    logic [1:0]       op;
    logic             neg;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sts_t;

endpackage

FILE: rtl/rtvs_unit.sv
`timescale 1ns / 1ps
module rtvs_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rtvs_pkg::cmd_t            cmd,
  input  logic [rtvs_pkg::DW-1:0]   opa,
  input  logic [rtvs_pkg::DW-1:0]   opb,
  input  logic [rtvs_pkg::DW-1:0]   opc,
  output rtvs_pkg::sts_t            sts,
  output logic [rtvs_pkg::DW-1:0]   result
);

  logic [rtvs_pkg::DW-1:0]    a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt, rem_r, rem_nxt;
  logic [rtvs_pkg::LEN_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]                 op_r, op_nxt;
  logic                       neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;

  logic [rtvs_pkg::DW-1:0] add_p, add_q;
  logic                    add_ci;
  logic [rtvs_pkg::DW:0]   add_res;
  logic                    ge;

  // one shared adder: accumulate for multiply, trial subtract for divide and root
  always_comb begin
    add_p  = '0;
    add_q  = '0;
    add_ci = 1'b0;
    case (op_r)
      rtvs_pkg::OP_MUL: begin
        add_p  = acc_r;
        add_q  = b_r[0] ? (neg_r ? ~a_r : a_r) : '0;
        add_ci = b_r[0] & neg_r;
      end
      rtvs_pkg::OP_DIV: begin
        add_p  = {rem_r[rtvs_pkg::DW-2:0], a_r[rtvs_pkg::DW-1]};
        add_q  = ~b_r;
        add_ci = 1'b1;
      end
      rtvs_pkg::OP_SQRT: begin
        add_p  = {rem_r[rtvs_pkg::DW-3:0], a_r[rtvs_pkg::DW-1 -: 2]};
        add_q  = ~{acc_r[rtvs_pkg::DW-3:0], 2'b01};
        add_ci = 1'b1;
      end
      default: begin
        add_p  = '0;
        add_q  = '0;
        add_ci = 1'b0;
      end
    endcase
    add_res = {1'b0, add_p} + {1'b0, add_q} + {{rtvs_pkg::DW{1'b0}}, add_ci};
    ge      = add_res[rtvs_pkg::DW];
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      a_nxt    = opa;
      b_nxt    = opb;
      op_nxt   = cmd.op;
      neg_nxt  = cmd.neg;
      cnt_nxt  = cmd.len;
      acc_nxt  = (cmd.op == rtvs_pkg::OP_MUL) ? opc : '0;
      rem_nxt  = (cmd.op == rtvs_pkg::OP_DIV) ? opc : '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      case (op_r)
        rtvs_pkg::OP_MUL: begin
          acc_nxt = add_res[rtvs_pkg::DW-1:0];
          a_nxt   = {a_r[rtvs_pkg::DW-2:0], 1'b0};
          b_nxt   = {1'b0, b_r[rtvs_pkg::DW-1:1]};
        end
        rtvs_pkg::OP_DIV: begin
          rem_nxt = ge ? add_res[rtvs_pkg::DW-1:0] : add_p;
          acc_nxt = {acc_r[rtvs_pkg::DW-2:0], ge};
          a_nxt   = {a_r[rtvs_pkg::DW-2:0], 1'b0};
        end
        rtvs_pkg::OP_SQRT: begin
          rem_nxt = ge ? add_res[rtvs_pkg::DW-1:0] : add_p;
          acc_nxt = {acc_r[rtvs_pkg::DW-2:0], ge};
          a_nxt   = {a_r[rtvs_pkg::DW-3:0], 2'b00};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == rtvs_pkg::LEN_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = acc_r;

endmodule

FILE: rtl/running_two_variable_statistics_top.sv
`timescale 1ns / 1ps
// Running statistics over signed 16-bit (x, y) pairs: count, min/max, Q.8 mean,
// Q.8 population deviation and Q1.14 correlation, one result transaction per
// input transaction. A counted pair is first accumulated through one 16x16 multiplier
// in states S_PXX, S_PXY, S_PYY and S_PEND, then up to sixteen multiply, divide
// and square-root passes use one shared 128-bit add/subtract unit that retires one
// multiplier bit, quotient bit or root bit per cycle. in_tready is high only
// while the block is idle; a finished result waits in the output register.
// Once the count reaches 65536 further pairs are dropped and tuser is set.
module running_two_variable_statistics_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // x_sample[15:0], y_sample[31:16]
  output logic         out_tvalid,
  input  logic         out_tready,
  // count_so_far, x_minimum, x_maximum, x_mean, x_deviation,
  // y_minimum, y_maximum, y_mean, y_deviation, correlation, zero pad
  output logic [199:0] out_tdata,
  output logic         out_tuser   // saturated
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PXX   = 3'd1;
  localparam logic [2:0] S_PXY   = 3'd2;
  localparam logic [2:0] S_PYY   = 3'd3;
  localparam logic [2:0] S_PEND  = 3'd4;
  localparam logic [2:0] S_ISSUE = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [3:0] U_NXQ   = 4'd0;
  localparam logic [3:0] U_DX    = 4'd1;
  localparam logic [3:0] U_NYQ   = 4'd2;
  localparam logic [3:0] U_DY    = 4'd3;
  localparam logic [3:0] U_NXY   = 4'd4;
  localparam logic [3:0] U_CC    = 4'd5;
  localparam logic [3:0] U_NN    = 4'd6;
  localparam logic [3:0] U_XMEAN = 4'd7;
  localparam logic [3:0] U_YMEAN = 4'd8;
  localparam logic [3:0] U_XVAR  = 4'd9;
  localparam logic [3:0] U_XDEV  = 4'd10;
  localparam logic [3:0] U_YVAR  = 4'd11;
  localparam logic [3:0] U_YDEV  = 4'd12;
  localparam logic [3:0] U_PROD  = 4'd13;
  localparam logic [3:0] U_ROOT  = 4'd14;
  localparam logic [3:0] U_CORR  = 4'd15;

  localparam int SB = rtvs_pkg::SAMPLE_BITS;
  localparam int DW = rtvs_pkg::DW;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  uop_r, uop_nxt;

  logic [rtvs_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic signed [rtvs_pkg::SUM_W-1:0] xs_r, xs_nxt, ys_r, ys_nxt;
  logic [rtvs_pkg::SQ_W-1:0]        xq_r, xq_nxt, yq_r, yq_nxt;
  logic signed [rtvs_pkg::XY_W-1:0] xy_r, xy_nxt;
  logic signed [SB-1:0] xmin_r, xmin_nxt, xmax_r, xmax_nxt;
  logic signed [SB-1:0] ymin_r, ymin_nxt, ymax_r, ymax_nxt;
  logic signed [SB-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [2*SB-1:0] prod_r, prod_nxt;
  logic sat_r, sat_nxt;

  logic [DW-1:0] t_r, t_nxt;
  logic [62:0]   dx_r, dx_nxt, dy_r, dy_nxt, s_r, s_nxt;
  logic [63:0]   cc_r, cc_nxt;
  logic [32:0]   nn_r, nn_nxt;
  logic [23:0]   xmean_r, xmean_nxt, xdev_r, xdev_nxt, ymean_r, ymean_nxt, ydev_r, ydev_nxt;
  logic [15:0]   corr_r, corr_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [199:0] out_data_r, out_data_nxt;
  logic         out_sat_r, out_sat_nxt;

  rtvs_pkg::cmd_t cmd;
  rtvs_pkg::sts_t sts;
  logic [DW-1:0]  opa, opb, opc, res;

  logic signed [SB-1:0]   in_x, in_y, mul_a, mul_b;
  logic signed [2*SB-1:0] mul_p;
  logic [31:0] xabs, yabs;
  logic [33:0] sxn;
  logic [62:0] cmag;
  logic [15:0] q14;

  assign in_x = in_tdata[SB-1:0];
  assign in_y = in_tdata[2*SB-1:SB];

  always_comb begin
    xabs = xs_r[rtvs_pkg::SUM_W-1] ? 32'(-xs_r) : 32'(xs_r);
    yabs = ys_r[rtvs_pkg::SUM_W-1] ? 32'(-ys_r) : 32'(ys_r);
    sxn  = ys_r[rtvs_pkg::SUM_W-1] ? -{xs_r[rtvs_pkg::SUM_W-1], xs_r}
                                   : {xs_r[rtvs_pkg::SUM_W-1], xs_r};
    cmag = cc_r[63] ? 63'(-cc_r) : cc_r[62:0];
    q14  = {2'b00, res[13:0]};
  end

  always_comb begin
    mul_a = x_r;
    mul_b = x_r;
    case (state_r)
      S_PXY:   mul_b = y_r;
      S_PYY: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      default: mul_b = x_r;
    endcase
    mul_p = mul_a * mul_b;
  end

  // operands of each pass through the shared unit
  always_comb begin
    cmd.start = (state_r == S_ISSUE);
    cmd.op    = rtvs_pkg::OP_MUL;
    cmd.neg   = 1'b0;
    cmd.len   = 7'd17;
    opa = '0;
    opb = {{(DW-rtvs_pkg::CNT_W){1'b0}}, cnt_r};
    opc = '0;
    case (uop_r)
      U_NXQ: opa = {{(DW-rtvs_pkg::SQ_W){1'b0}}, xq_r};
      U_DX: begin
        opa = {96'd0, xabs};
        opb = {96'd0, xabs};
        opc = t_r;
        cmd.neg = 1'b1;
        cmd.len = 7'd32;
      end
      U_NYQ: opa = {{(DW-rtvs_pkg::SQ_W){1'b0}}, yq_r};
      U_DY: begin
        opa = {96'd0, yabs};
        opb = {96'd0, yabs};
        opc = t_r;
        cmd.neg = 1'b1;
        cmd.len = 7'd32;
      end
      U_NXY: opa = {{(DW-rtvs_pkg::XY_W){xy_r[rtvs_pkg::XY_W-1]}}, xy_r};
      U_CC: begin
        opa = {{94{sxn[33]}}, sxn};
        opb = {96'd0, yabs};
        opc = t_r;
        cmd.neg = 1'b1;
        cmd.len = 7'd32;
      end
      U_NN: opa = {{(DW-rtvs_pkg::CNT_W){1'b0}}, cnt_r};
      U_XMEAN: begin
        cmd.op  = rtvs_pkg::OP_DIV;
        cmd.len = 7'd40;
        opa = {xabs, 96'd0};
      end
      U_YMEAN: begin
        cmd.op  = rtvs_pkg::OP_DIV;
        cmd.len = 7'd40;
        opa = {yabs, 96'd0};
      end
      U_XVAR: begin
        cmd.op  = rtvs_pkg::OP_DIV;
        cmd.len = 7'd79;
        opa = {dx_r, 65'd0};
        opb = {95'd0, nn_r};
      end
      U_XDEV, U_YDEV: begin
        cmd.op  = rtvs_pkg::OP_SQRT;
        cmd.len = 7'd24;
        opa = {t_r[47:0], 80'd0};
      end
      U_YVAR: begin
        cmd.op  = rtvs_pkg::OP_DIV;
        cmd.len = 7'd79;
        opa = {dy_r, 65'd0};
        opb = {95'd0, nn_r};
      end
      U_PROD: begin
        cmd.len = 7'd63;
        opa = {65'd0, dx_r};
        opb = {65'd0, dy_r};
      end
      U_ROOT: begin
        cmd.op  = rtvs_pkg::OP_SQRT;
        cmd.len = 7'd64;
        opa = t_r;
      end
      U_CORR: begin
        cmd.op  = rtvs_pkg::OP_DIV;
        cmd.len = 7'd14;
        opb = {65'd0, s_r};
        opc = {65'd0, cmag};
      end
      default: opa = '0;
    endcase
  end

  rtvs_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .opa    (opa),
    .opb    (opb),
    .opc    (opc),
    .sts    (sts),
    .result (res)
  );

  always_comb begin
    state_nxt = state_r;
    uop_nxt   = uop_r;
    cnt_nxt   = cnt_r;
    xs_nxt = xs_r;  ys_nxt = ys_r;
    xq_nxt = xq_r;  yq_nxt = yq_r;
    xy_nxt = xy_r;
    xmin_nxt = xmin_r;  xmax_nxt = xmax_r;
    ymin_nxt = ymin_r;  ymax_nxt = ymax_r;
    x_nxt = x_r;  y_nxt = y_r;
    prod_nxt = prod_r;
    sat_nxt  = sat_r;
    t_nxt = t_r;  dx_nxt = dx_r;  dy_nxt = dy_r;  s_nxt = s_r;
    cc_nxt = cc_r;  nn_nxt = nn_r;
    xmean_nxt = xmean_r;  xdev_nxt = xdev_r;
    ymean_nxt = ymean_r;  ydev_nxt = ydev_r;
    corr_nxt  = corr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt   = in_x;
          y_nxt   = in_y;
          uop_nxt = U_NXQ;
          if (cnt_r == rtvs_pkg::CNT_W'(rtvs_pkg::MAX_SAMPLES)) begin
            sat_nxt   = 1'b1;
            state_nxt = S_ISSUE;
          end else begin
            sat_nxt = 1'b0;
            cnt_nxt = cnt_r + 1'b1;
            xs_nxt  = xs_r + rtvs_pkg::SUM_W'(in_x);
            ys_nxt  = ys_r + rtvs_pkg::SUM_W'(in_y);
            if (in_x < xmin_r) xmin_nxt = in_x;
            if (in_x > xmax_r) xmax_nxt = in_x;
            if (in_y < ymin_r) ymin_nxt = in_y;
            if (in_y > ymax_r) ymax_nxt = in_y;
            state_nxt = S_PXX;
          end
        end
      end
      S_PXX: begin
        prod_nxt  = mul_p;
        state_nxt = S_PXY;
      end
      S_PXY: begin
        xq_nxt    = xq_r + rtvs_pkg::SQ_W'(unsigned'(prod_r));
        prod_nxt  = mul_p;
        state_nxt = S_PYY;
      end
      S_PYY: begin
        xy_nxt    = xy_r + rtvs_pkg::XY_W'(prod_r);
        prod_nxt  = mul_p;
        state_nxt = S_PEND;
      end
      S_PEND: begin
        yq_nxt    = yq_r + rtvs_pkg::SQ_W'(unsigned'(prod_r));
        state_nxt = S_ISSUE;
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (sts.done) begin
          uop_nxt   = uop_r + 1'b1;
          state_nxt = S_ISSUE;
          case (uop_r)
            U_NXQ, U_NYQ, U_NXY, U_XVAR, U_YVAR, U_PROD: t_nxt = res;
            U_DX:    dx_nxt = res[62:0];
            U_DY:    dy_nxt = res[62:0];
            U_CC:    cc_nxt = res[63:0];
            U_NN:    nn_nxt = res[32:0];
            U_XMEAN: xmean_nxt = xs_r[rtvs_pkg::SUM_W-1] ? -res[23:0] : res[23:0];
            U_YMEAN: ymean_nxt = ys_r[rtvs_pkg::SUM_W-1] ? -res[23:0] : res[23:0];
            U_XDEV:  xdev_nxt = res[23:0];
            U_YDEV:  ydev_nxt = res[23:0];
            U_ROOT: begin
              s_nxt = res[62:0];
              if (cnt_r < rtvs_pkg::CNT_W'(2) || res[62:0] == 63'd0) begin
                corr_nxt  = '0;
                state_nxt = S_OUT;
              end else if (cmag >= res[62:0]) begin
                corr_nxt  = cc_r[63] ? -16'sd16384 : 16'sd16384;
                state_nxt = S_OUT;
              end
            end
            U_CORR: begin
              corr_nxt  = cc_r[63] ? -q14 : q14;
              state_nxt = S_OUT;
            end
            default: t_nxt = t_r;
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sat_nxt   = sat_r;
          out_data_nxt  = {7'd0, corr_r, ydev_r, ymean_r, ymax_r, ymin_r,
                           xdev_r, xmean_r, xmax_r, xmin_r, cnt_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      uop_r       <= U_NXQ;
      cnt_r       <= '0;
      xs_r        <= '0;
      ys_r        <= '0;
      xq_r        <= '0;
      yq_r        <= '0;
      xy_r        <= '0;
      xmin_r      <= {1'b0, {(SB-1){1'b1}}};
      ymin_r      <= {1'b0, {(SB-1){1'b1}}};
      xmax_r      <= {1'b1, {(SB-1){1'b0}}};
      ymax_r      <= {1'b1, {(SB-1){1'b0}}};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      uop_r       <= uop_nxt;
      cnt_r       <= cnt_nxt;
      xs_r        <= xs_nxt;
      ys_r        <= ys_nxt;
      xq_r        <= xq_nxt;
      yq_r        <= yq_nxt;
      xy_r        <= xy_nxt;
      xmin_r      <= xmin_nxt;
      ymin_r      <= ymin_nxt;
      xmax_r      <= xmax_nxt;
      ymax_r      <= ymax_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    prod_r     <= prod_nxt;
    sat_r      <= sat_nxt;
    t_r        <= t_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    s_r        <= s_nxt;
    cc_r       <= cc_nxt;
    nn_r       <= nn_nxt;
    xmean_r    <= xmean_nxt;
    xdev_r     <= xdev_nxt;
    ymean_r    <= ymean_nxt;
    ydev_r     <= ydev_nxt;
    corr_r     <= corr_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a pair is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rtvs_pkg::CNT_W'(rtvs_pkg::MAX_SAMPLES))
    else $error("sample count beyond limit");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> state_r == S_WAIT)
    else $error("unit finished outside wait state");

  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[192:177]) <= 16'sd16384 &&
                    $signed(out_tdata[192:177]) >= -16'sd16384))
    else $error("correlation out of range");

endmodule
